@@ hdl/dqsr_pkg.sv @@
// Shared types, constants and a helper function of the captive portal DNS responder.
`default_nettype none

package dqsr_pkg;

   // Default largest packet, in bytes, for query and answer alike.
   localparam int DEF_MAX_PACKET = 512;

   // Fixed layout of a DNS message and of the appended A record.
   localparam int HDR_LEN = 12;
   localparam int ANS_LEN = 16;
   localparam int ANS_IDX_W = $clog2(ANS_LEN);
   localparam int QTAIL_LEN = 5;          // zero byte plus type and class
   localparam int CSR_W = 32;

   // Depth of the command queue between front and back; a power of two.
   localparam int QUEUE_DEPTH = 4;

   // Header offsets that are read or rewritten.
   localparam logic [3:0] HDR_FLAGS_HI = 4'd2;
   localparam logic [3:0] HDR_FLAGS_LO = 4'd3;
   localparam logic [3:0] HDR_QD_HI    = 4'd4;
   localparam logic [3:0] HDR_QD_LO    = 4'd5;
   localparam logic [3:0] HDR_AN_HI    = 4'd6;
   localparam logic [3:0] HDR_AN_LO    = 4'd7;
   localparam logic [3:0] HDR_NS_HI    = 4'd8;
   localparam logic [3:0] HDR_NS_LO    = 4'd9;
   localparam logic [3:0] HDR_AR_HI    = 4'd10;
   localparam logic [3:0] HDR_AR_LO    = 4'd11;

   localparam logic [7:0] FLAGS_HI = 8'h81;
   localparam logic [7:0] FLAGS_LO = 8'h80;
   localparam logic [7:0] NAME_PTR_HI = 8'hC0;
   localparam logic [7:0] NAME_PTR_LO = 8'h0C;
   localparam logic [7:0] TYPE_A_LO = 8'h01;
   localparam logic [7:0] CLASS_IN_LO = 8'h01;
   localparam logic [7:0] TTL_LO = 8'h3C;
   localparam logic [7:0] RDLEN_LO = 8'h04;

   // One beat of the query.
   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } req_beat_type;

   // One beat of the response.
   typedef struct packed {
      logic [7:0] data_res;
      logic       last_res;
      logic       error;
   } rsp_beat_type;

   // What the back end has to do for one queued command.
   typedef enum logic [1:0] {
      CMD_BYTE        = 2'd0,
      CMD_BYTE_ANSWER = 2'd1,
      CMD_ERROR       = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   data;
   } cmd_type;

   // Byte of the appended A record at the given offset.
   function automatic logic [7:0] ans_byte(input logic [ANS_IDX_W-1:0] idx,
                                           input logic [CSR_W-1:0] ip);
      logic [7:0] b;
      unique case (idx)
         4'd0:    b = NAME_PTR_HI;
         4'd1:    b = NAME_PTR_LO;
         4'd3:    b = TYPE_A_LO;
         4'd5:    b = CLASS_IN_LO;
         4'd9:    b = TTL_LO;
         4'd11:   b = RDLEN_LO;
         4'd12:   b = ip[31:24];
         4'd13:   b = ip[23:16];
         4'd14:   b = ip[15:8];
         4'd15:   b = ip[7:0];
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

@@ hdl/dqsr_front.sv @@
// Front end: tracks the query layout and turns each byte into a back-end command.
`default_nettype none

module dqsr_front #(
   parameter int MAX_PACKET = dqsr_pkg::DEF_MAX_PACKET
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire dqsr_pkg::req_beat_type beat,
   output logic                       push,
   output dqsr_pkg::cmd_type          cmd
);
   import dqsr_pkg::*;

   localparam int IDX_W = $clog2(MAX_PACKET + 1);
   localparam int SUM_W = $clog2(MAX_PACKET + HDR_LEN + ANS_LEN + 256 + 1);

   typedef enum logic [3:0] {
      PH_LABELS = 4'b0001,
      PH_TYPE   = 4'b0010,
      PH_TRAIL  = 4'b0100,
      PH_DROP   = 4'b1000
   } phase_type;

   logic [IDX_W-1:0] byte_index_ff, byte_index_in;
   logic [IDX_W-1:0] next_label_ff, next_label_in;
   logic [IDX_W-1:0] qend_ff, qend_in;
   logic [15:0]      count_ff, count_in;
   phase_type        phase_ff, phase_in;

   logic             emit;
   logic             fail;
   logic             active;
   logic [SUM_W-1:0] label_sum;
   logic [SUM_W-1:0] qend_sum;
   logic [7:0]       hdr_byte;

   assign active = (byte_index_ff < IDX_W'(MAX_PACKET)) &&
                   ((phase_ff == PH_LABELS) || (phase_ff == PH_TYPE));
   assign label_sum = SUM_W'(byte_index_ff) + SUM_W'(beat.data) + SUM_W'(1);
   assign qend_sum = SUM_W'(byte_index_ff) + SUM_W'(QTAIL_LEN);

   // Header rewrite; the question count is held for the answer count.
   always_comb begin
      unique case (byte_index_ff[3:0])
         HDR_FLAGS_HI: hdr_byte = FLAGS_HI;
         HDR_FLAGS_LO: hdr_byte = FLAGS_LO;
         HDR_AN_HI:    hdr_byte = count_ff[15:8];
         HDR_AN_LO:    hdr_byte = count_ff[7:0];
         HDR_NS_HI, HDR_NS_LO, HDR_AR_HI, HDR_AR_LO: hdr_byte = 8'h00;
         default:      hdr_byte = beat.data;
      endcase
   end

   // Classification of one accepted byte.
   always_comb begin
      byte_index_in = byte_index_ff;
      next_label_in = next_label_ff;
      qend_in       = qend_ff;
      count_in      = count_ff;
      phase_in      = phase_ff;
      emit          = 1'b0;
      fail          = 1'b0;
      cmd.kind      = CMD_BYTE;
      cmd.data      = beat.data;

      if (active) begin
         if (byte_index_ff < IDX_W'(HDR_LEN)) begin
            emit     = 1'b1;
            cmd.data = hdr_byte;
            if (byte_index_ff[3:0] == HDR_QD_HI) begin
               count_in[15:8] = beat.data;
            end
            if (byte_index_ff[3:0] == HDR_QD_LO) begin
               count_in[7:0] = beat.data;
            end
         end else if (phase_ff == PH_LABELS) begin
            if (byte_index_ff == next_label_ff) begin
               if (beat.data == 8'h00) begin
                  qend_in = IDX_W'(qend_sum);
                  if ((qend_sum + SUM_W'(ANS_LEN)) > SUM_W'(MAX_PACKET)) begin
                     fail = 1'b1;
                  end else begin
                     phase_in = PH_TYPE;
                  end
               end else begin
                  next_label_in = IDX_W'(label_sum);
                  if (label_sum >= SUM_W'(MAX_PACKET)) begin
                     fail = 1'b1;
                  end
               end
            end
            emit = !fail;
         end else begin
            emit = 1'b1;
            if ((byte_index_ff + IDX_W'(1)) == qend_ff) begin
               cmd.kind = CMD_BYTE_ANSWER;
               phase_in = PH_TRAIL;
            end
         end
      end

      // A failure, or a query that ends before its question does, gives an error beat.
      if (fail) begin
         emit     = 1'b1;
         cmd.kind = CMD_ERROR;
         cmd.data = 8'h00;
         phase_in = PH_DROP;
      end else if (beat.last && ((phase_in == PH_LABELS) || (phase_in == PH_TYPE))) begin
         emit     = 1'b1;
         cmd.kind = CMD_ERROR;
         cmd.data = 8'h00;
      end

      if (byte_index_ff < IDX_W'(MAX_PACKET)) begin
         byte_index_in = byte_index_ff + IDX_W'(1);
      end

      // The final byte puts the packet state back for the next query.
      if (beat.last) begin
         byte_index_in = '0;
         next_label_in = IDX_W'(HDR_LEN);
         qend_in       = '0;
         count_in      = '0;
         phase_in      = PH_LABELS;
      end
   end

   assign push = accept && emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff <= '0;
         next_label_ff <= IDX_W'(HDR_LEN);
         qend_ff       <= '0;
         count_ff      <= '0;
         phase_ff      <= PH_LABELS;
      end else if (accept) begin
         byte_index_ff <= byte_index_in;
         next_label_ff <= next_label_in;
         qend_ff       <= qend_in;
         count_ff      <= count_in;
         phase_ff      <= phase_in;
      end
   end

   // Past the header in the label walk, the next label never lies beyond the packet.
   a_label_in_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_LABELS) |-> (next_label_ff < IDX_W'(MAX_PACKET)))
      else $error("label offset out of range while walking labels");

endmodule

`default_nettype wire

@@ hdl/dqsr_queue.sv @@
// Short command queue that decouples the front end from the back end.
`default_nettype none

module dqsr_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire dqsr_pkg::cmd_type push_cmd,
   input  wire logic              pop,
   output logic                   full,
   output logic                   head_valid,
   output dqsr_pkg::cmd_type      head_cmd
);
   import dqsr_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = slot_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Slot storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("command pushed into a full queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue fill count beyond its depth");

endmodule

`default_nettype wire

@@ hdl/dqsr_back.sv @@
// Back end: carries out queued commands and drives the registered response beat.
`default_nettype none

module dqsr_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [dqsr_pkg::CSR_W-1:0] ap_ip,
   input  wire logic                   head_valid,
   input  wire dqsr_pkg::cmd_type      head_cmd,
   output logic                        pop,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output dqsr_pkg::rsp_beat_type      rsp_beat
);
   import dqsr_pkg::*;

   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_beat_type         rsp_beat_ff, rsp_beat_in;
   logic                 ans_busy_ff, ans_busy_in;
   logic [ANS_IDX_W-1:0] ans_idx_ff, ans_idx_in;
   logic                 load;
   logic                 ans_end;

   assign load    = !rsp_valid_ff || !rsp_stall;
   assign ans_end = (ans_idx_ff == ANS_IDX_W'(ANS_LEN - 1));

   // Next response beat: answer record first, then the head of the queue.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_beat_in  = rsp_beat_ff;
      ans_busy_in  = ans_busy_ff;
      ans_idx_in   = ans_idx_ff;
      pop          = 1'b0;
      if (load) begin
         if (ans_busy_ff) begin
            rsp_valid_in         = 1'b1;
            rsp_beat_in.data_res = ans_byte(ans_idx_ff, ap_ip);
            rsp_beat_in.last_res = ans_end;
            rsp_beat_in.error    = 1'b0;
            ans_idx_in           = ans_idx_ff + ANS_IDX_W'(1);
            ans_busy_in          = !ans_end;
         end else if (head_valid) begin
            pop                  = 1'b1;
            rsp_valid_in         = 1'b1;
            rsp_beat_in.data_res = head_cmd.data;
            rsp_beat_in.last_res = 1'b0;
            rsp_beat_in.error    = 1'b0;
            unique case (head_cmd.kind)
               CMD_BYTE: begin
               end
               CMD_BYTE_ANSWER: begin
                  ans_busy_in = 1'b1;
                  ans_idx_in  = '0;
               end
               CMD_ERROR: begin
                  rsp_beat_in.data_res = 8'h00;
                  rsp_beat_in.last_res = 1'b1;
                  rsp_beat_in.error    = 1'b1;
               end
               default: begin
               end
            endcase
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         ans_busy_ff  <= 1'b0;
         ans_idx_ff   <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         ans_busy_ff  <= ans_busy_in;
         ans_idx_ff   <= ans_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_beat_ff <= rsp_beat_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_beat_ff;

   // While the record streams out, a record beat is always on offer.
   a_busy_valid: assert property (@(posedge clock) disable iff (reset)
      ans_busy_ff |-> rsp_valid_ff)
      else $error("answer record in progress without a response beat");

   // An error beat is always the closing, zero-valued beat.
   a_error_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_beat_ff.error) |->
         (rsp_beat_ff.last_res && (rsp_beat_ff.data_res == 8'h00)))
      else $error("malformed error beat");

   // The queue is not drained in the middle of an answer record.
   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      ans_busy_ff |-> !pop)
      else $error("command taken during answer record");

endmodule

`default_nettype wire

@@ hdl/dns_query_spoof_responder_core.sv @@
// Top level of the captive portal DNS responder: front end, command queue, back end.
//
// Usage: query bytes enter on the req_ channel, one beat per byte with last on the
// final byte. Every answer byte leaves on the rsp_ channel. The header is rewritten
// as it passes, the question is copied, trailing bytes are dropped and a 16-byte A
// record carrying csr_write_data's address (written through csr_write_en) follows
// the class field. A malformed or truncated query closes with one error beat; all
// beats sent for that query must then be discarded.
// Path: a byte accepted is written into the command queue, then loaded into the
// registered rsp beat when the output is free. Throughput: one query byte per cycle
// while req_stall is low; while an answer record streams out the back end takes no
// command, so the four-entry queue fills and req_stall rises only when it is full.
// Reset (synchronous) clears the packet state, the queue and the output valid flag,
// and sets the configured address to zero. When the receiver raises rsp_stall the
// current beat holds; the queue keeps taking bytes until it fills.
`default_nettype none

module dns_query_spoof_responder_core #(
   parameter int MAX_PACKET = dqsr_pkg::DEF_MAX_PACKET
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire dqsr_pkg::req_beat_type     req_beat,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output dqsr_pkg::rsp_beat_type          rsp_beat,
   input  wire logic                       csr_write_en,
   input  wire logic [dqsr_pkg::CSR_W-1:0] csr_write_data
);
   import dqsr_pkg::*;

   logic [CSR_W-1:0] ap_ip_ff;
   logic             accept;
   logic             push;
   cmd_type          push_cmd;
   logic             pop;
   logic             full;
   logic             head_valid;
   cmd_type          head_cmd;

   // Configured answer address.
   always_ff @(posedge clock) begin
      if (reset) begin
         ap_ip_ff <= '0;
      end else if (csr_write_en) begin
         ap_ip_ff <= csr_write_data;
      end
   end

   assign req_stall = full;
   assign accept    = req_valid && !req_stall;

   dqsr_front #(
      .MAX_PACKET(MAX_PACKET)
   ) u_front (
      .clock (clock),
      .reset (reset),
      .accept(accept),
      .beat  (req_beat),
      .push  (push),
      .cmd   (push_cmd)
   );

   dqsr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .pop       (pop),
      .full      (full),
      .head_valid(head_valid),
      .head_cmd  (head_cmd)
   );

   dqsr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .ap_ip     (ap_ip_ff),
      .head_valid(head_valid),
      .head_cmd  (head_cmd),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_beat  (rsp_beat)
   );

endmodule

`default_nettype wire
